[rtl/aes_pkg.sv]
// shared types, constants and functions for the aes-128 encryption pipeline
`timescale 1ns / 1ps
package aes_pkg;

    localparam int NUM_ROUNDS   = 10;
    localparam int BLOCK_W      = 128;
    localparam int HALF_W       = 64;
    localparam int CFG_IDX_W    = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } t_cfg_idx;

    typedef logic [7:0] t_byte;
    typedef logic [BLOCK_W-1:0] t_block;

    // data handed from one round cell to the next
    typedef struct packed {
        logic   vld;
        t_block state;
        t_block rkey;
    } t_stage;

    localparam t_byte SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam t_byte RCON [NUM_ROUNDS] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic t_byte get_byte(input t_block b, input int i);
        get_byte = b[BLOCK_W-1-8*i -: 8];
    endfunction

    function automatic t_byte gf_double(input t_byte v);
        gf_double = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // one aes-128 key schedule step, rc is the round constant
    function automatic t_block next_key(input t_block k, input t_byte rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        next_key = {w0, w1, w2, w3};
    endfunction

    // subbytes, shiftrows and optional mixcolumns
    function automatic t_block round_core(input t_block s, input logic do_mix);
        t_byte  sb [16];
        t_byte  a0, a1, a2, a3, al;
        t_block res;
        res = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sb[c*4+r] = SBOX[get_byte(s, ((c + r) % 4) * 4 + r)];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = sb[c*4];
            a1 = sb[c*4+1];
            a2 = sb[c*4+2];
            a3 = sb[c*4+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            if (do_mix) begin
                a0 = sb[c*4]   ^ al ^ gf_double(sb[c*4]   ^ sb[c*4+1]);
                a1 = sb[c*4+1] ^ al ^ gf_double(sb[c*4+1] ^ sb[c*4+2]);
                a2 = sb[c*4+2] ^ al ^ gf_double(sb[c*4+2] ^ sb[c*4+3]);
                a3 = sb[c*4+3] ^ al ^ gf_double(sb[c*4+3] ^ sb[c*4]);
            end
            res[BLOCK_W-1-32*c -: 32] = {a0, a1, a2, a3};
        end
        round_core = res;
    endfunction

endpackage

[rtl/aes_stream_if.sv]
// valid/ready channel carrying one 128-bit block as two halves
`timescale 1ns / 1ps
interface aes_stream_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_high;
    logic [63:0] data_low;

    modport source (output valid, output data_high, output data_low, input ready);
    modport sink   (input valid, input data_high, input data_low, output ready);
endinterface

[rtl/aes128_block_encrypt.sv]
// top level: aes-128 encryption as a row of eleven registered round cells
//
//   channel   dir  fields                    handshake
//   s_in      in   data_high/low = plain     valid/ready
//   m_out     out  data_high/low = cipher    valid/ready
//   cfg       in   i_cfg_idx, i_cfg_data     i_cfg_we
//
// one item per cycle sustained while the output side takes results
// each round cell holds one item and its round key; the key schedule rides along
// the whole row advances together; it stalls only when the last cell is full
// and the output is not taken, and then the input waits as well
// synchronous active-low reset clears the valid bits and the key registers
`timescale 1ns / 1ps
module aes128_block_encrypt
    import aes_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [HALF_W-1:0] i_cfg_data,
    aes_stream_if.sink        s_in,
    aes_stream_if.source      m_out
);
    logic [HALF_W-1:0] r_key_high;
    logic [HALF_W-1:0] r_key_low;
    t_stage            r_init;
    t_stage            w_stage [NUM_ROUNDS+1];
    logic              w_adv;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_KEY_HIGH: r_key_high <= i_cfg_data;
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // whole row moves when the output cell is empty or being drained
    assign w_adv      = !w_stage[NUM_ROUNDS].vld || m_out.ready;
    assign s_in.ready = w_adv;

    // initial addroundkey cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init.vld <= 1'b0;
        end else if (w_adv) begin
            r_init.vld <= s_in.valid;
        end
        if (w_adv) begin
            r_init.rkey  <= {r_key_high, r_key_low};
            r_init.state <= {s_in.data_high, s_in.data_low} ^ {r_key_high, r_key_low};
        end
    end

    assign w_stage[0] = r_init;

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        aes_round_cell #(
            .RC   (RCON[g]),
            .LAST (g == NUM_ROUNDS - 1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_stage (w_stage[g]),
            .o_stage (w_stage[g+1])
        );
    end

    assign m_out.valid     = w_stage[NUM_ROUNDS].vld;
    assign m_out.data_high = w_stage[NUM_ROUNDS].state[BLOCK_W-1:HALF_W];
    assign m_out.data_low  = w_stage[NUM_ROUNDS].state[HALF_W-1:0];

    // a held result must stay valid and its high half must not change while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid && $stable(m_out.data_high))
        else $error("result changed while stalled");
    // input is always ready while output slot is free
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_out.valid |-> s_in.ready)
        else $error("stalled with empty output");
    // an accepted item reaches the first cell
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in.valid && s_in.ready |=> r_init.vld)
        else $error("accepted item lost");
endmodule

[rtl/aes_round_cell.sv]
// one round cell: round transform of the state and next round key, registered
`timescale 1ns / 1ps
module aes_round_cell
    import aes_pkg::*;
#(
    parameter logic [7:0] RC      = 8'h01,
    parameter bit         LAST    = 1'b0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_stage i_stage,
    output t_stage o_stage
);
    t_stage r_stage;
    t_block n_key;

    always_comb begin
        n_key = next_key(i_stage.rkey, RC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.vld <= 1'b0;
        end else if (i_en) begin
            r_stage.vld <= i_stage.vld;
        end
        if (i_en) begin
            r_stage.rkey  <= n_key;
            r_stage.state <= round_core(i_stage.state, !LAST) ^ n_key;
        end
    end

    assign o_stage = r_stage;
endmodule

[dv/tb_top.sv]
// self-checking testbench for the aes-128 block encryption pipeline
`timescale 1ns / 1ps
module tb_top
    import aes_pkg::*;
();

    // ---------------------------------------------------------------------
    // clock, reset and block hookup
    // ---------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [HALF_W-1:0] i_cfg_data;

    aes_stream_if plain_ch ();
    aes_stream_if cipher_ch ();

    aes128_block_encrypt u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (plain_ch.sink),
        .m_out      (cipher_ch.source)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 30;

    // ---------------------------------------------------------------------
    // predictor: aes-128 encryption under the testbench copy of the key
    // ---------------------------------------------------------------------
    logic [63:0] key_hi_shadow;
    logic [63:0] key_lo_shadow;

    function automatic t_byte sbox_lookup(input t_byte v);
        t_byte tab [256];
        tab = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,
            8'hd7,8'hab,8'h76,8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,
            8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,
            8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,8'h04,8'hc7,8'h23,8'hc3,
            8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,8'h09,
            8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,
            8'h2f,8'h84,8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,
            8'h39,8'h4a,8'h4c,8'h58,8'hcf,8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
            8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,8'h51,8'ha3,8'h40,8'h8f,8'h92,
            8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,8'hcd,8'h0c,
            8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,
            8'h73,8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,
            8'hde,8'h5e,8'h0b,8'hdb,8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,
            8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,
            8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,8'hba,8'h78,8'h25,
            8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,
            8'hc1,8'h1d,8'h9e,8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,
            8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,
            8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return tab[v];
    endfunction

    function automatic t_byte xtime(input t_byte v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // byte 0 of the array is the most significant byte of the block
    function automatic t_block encrypt_block(input t_block key, input t_block plain);
        t_byte  rk [176];
        t_byte  st [16];
        t_byte  tmp [16];
        t_byte  t [4];
        t_byte  rc;
        t_byte  first, a0, a1, a2, a3, al;
        t_block res;
        for (int i = 0; i < 16; i++) begin
            rk[i] = key[127-8*i -: 8];
            st[i] = plain[127-8*i -: 8];
        end
        // key expansion, round constant doubles each round
        rc = 8'h01;
        for (int i = 16; i < 176; i += 4) begin
            for (int j = 0; j < 4; j++) t[j] = rk[i-4+j];
            if ((i % 16) == 0) begin
                first = t[0];
                t[0] = sbox_lookup(t[1]) ^ rc;
                t[1] = sbox_lookup(t[2]);
                t[2] = sbox_lookup(t[3]);
                t[3] = sbox_lookup(first);
                rc = xtime(rc);
            end
            for (int j = 0; j < 4; j++) rk[i+j] = rk[i-16+j] ^ t[j];
        end
        for (int i = 0; i < 16; i++) st[i] ^= rk[i];
        for (int r = 1; r <= 10; r++) begin
            // subbytes and shiftrows together
            for (int c = 0; c < 4; c++)
                for (int w = 0; w < 4; w++)
                    tmp[c*4+w] = sbox_lookup(st[((c + w) % 4) * 4 + w]);
            // the last round skips mixcolumns
            if (r < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = tmp[c*4];
                    a1 = tmp[c*4+1];
                    a2 = tmp[c*4+2];
                    a3 = tmp[c*4+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    tmp[c*4]   = a0 ^ al ^ xtime(a0 ^ a1);
                    tmp[c*4+1] = a1 ^ al ^ xtime(a1 ^ a2);
                    tmp[c*4+2] = a2 ^ al ^ xtime(a2 ^ a3);
                    tmp[c*4+3] = a3 ^ al ^ xtime(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ rk[16*r+i];
        end
        for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // stimulus queue, expected ciphertext queue, status
    // ---------------------------------------------------------------------
    t_block plain_queue [$];
    t_block cipher_expected [$];
    int     error_count;
    int     idle_cycles;
    int     sent_count;
    logic   timed_out;

    // ---------------------------------------------------------------------
    // driver: bursts of random length with random gaps
    // ---------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            plain_ch.valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            // item taken at this edge: predict it and retire it from the queue
            if (plain_ch.valid && plain_ch.ready) begin
                cipher_expected.push_back(encrypt_block({key_hi_shadow, key_lo_shadow},
                                                        {plain_ch.data_high,
                                                         plain_ch.data_low}));
                void'(plain_queue.pop_front());
                sent_count <= sent_count + 1;
            end
            if (plain_ch.valid && !plain_ch.ready) begin
                // hold the item until it is taken
            end else if (gap_left > 0) begin
                plain_ch.valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (plain_queue.size() > 0) begin
                // the front of the queue is the next item to send
                {plain_ch.data_high, plain_ch.data_low} <= plain_queue[0];
                plain_ch.valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 30);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                plain_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // monitor: receiver stall pattern and comparison against the oldest prediction
    // ---------------------------------------------------------------------
    int stall_mode;
    int stall_phase;
    t_block want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cipher_ch.ready <= 1'b0;
            stall_mode <= 0;
            stall_phase <= 0;
        end else begin
            if (cipher_ch.valid && cipher_ch.ready) begin
                if (cipher_expected.size() == 0) begin
                    $display("%0t: unexpected cipher item %h_%h", $time,
                             cipher_ch.data_high, cipher_ch.data_low);
                    error_count <= error_count + 1;
                end else begin
                    want = cipher_expected.pop_front();
                    if (cipher_ch.data_high !== want[127:64]) begin
                        $display("%0t: cipher_high expected %h actual %h", $time,
                                 want[127:64], cipher_ch.data_high);
                    end
                    if (cipher_ch.data_low !== want[63:0]) begin
                        $display("%0t: cipher_low expected %h actual %h", $time,
                                 want[63:0], cipher_ch.data_low);
                    end
                    if (cipher_ch.data_high !== want[127:64]
                        || cipher_ch.data_low !== want[63:0]) begin
                        error_count <= error_count + 1;
                    end
                end
            end
            // modes: always ready, periodic stall, random stall, long hold-off
            if (stall_phase >= 200) begin
                stall_phase <= 0;
                stall_mode <= $urandom_range(0, 3);
            end else begin
                stall_phase <= stall_phase + 1;
            end
            case (stall_mode)
                0: begin
                    cipher_ch.ready <= 1'b1;
                end
                1: begin
                    cipher_ch.ready <= (stall_phase % 5) != 0;
                end
                2: begin
                    cipher_ch.ready <= $urandom_range(0, 2) != 0;
                end
                default: begin
                    cipher_ch.ready <= (stall_phase % 40) >= 25;
                end
            endcase
        end
    end

    // watchdog on cycles with no accepted item on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (plain_ch.valid && plain_ch.ready)
            || (cipher_ch.valid && cipher_ch.ready)) begin
            idle_cycles <= 0;
        end else if (cipher_expected.size() > 0 || plain_queue.size() > 0) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                timed_out <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (timed_out) begin
            $display("aes128_block_encrypt verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // sequencing: key phases, directed blocks, random blocks
    // ---------------------------------------------------------------------
    // one write cycle on the config port, then write enable is low again before the task returns
    task automatic write_key_reg(input t_cfg_idx idx, input logic [63:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_KEY_HIGH) key_hi_shadow = value;
        else key_lo_shadow = value;
        @(posedge i_clk);
    endtask

    // wait until every item is in and every ciphertext has come back
    task automatic drain_all();
        while (plain_queue.size() > 0 || cipher_expected.size() > 0 || plain_ch.valid)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // random plaintext with occasional sparse or saturated halves
    function automatic t_block random_block();
        t_block b;
        b = {rand64(), rand64()};
        case ($urandom_range(0, 9))
            0: b[127:64] = '0;
            1: b[63:0] = '1;
            2: b = t_block'(1) << $urandom_range(0, 127);
            default: ;
        endcase
        return b;
    endfunction

    initial begin
        error_count = 0;
        sent_count = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        key_hi_shadow = '0;
        key_lo_shadow = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_KEY_HIGH;
        i_cfg_data = '0;
        plain_ch.valid = 1'b0;
        plain_ch.data_high = '0;
        plain_ch.data_low = '0;
        cipher_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // key never written: the all-zero reset key
        plain_queue.push_back('0);
        plain_queue.push_back('1);
        drain_all();

        // fips-197 appendix key, then the standard vector and field extremes
        write_key_reg(REG_KEY_HIGH, 64'h2b7e151628aed2a6);
        write_key_reg(REG_KEY_LOW, 64'habf7158809cf4f3c);
        plain_queue.push_back(128'h3243f6a8885a308d313198a2e0370734);
        plain_queue.push_back('0);
        plain_queue.push_back('1);
        plain_queue.push_back({64'hffffffffffffffff, 64'h0});
        plain_queue.push_back({64'h0, 64'hffffffffffffffff});
        plain_queue.push_back(128'h5555aaaa5555aaaa5555aaaa5555aaaa);
        plain_queue.push_back(128'h80000000000000000000000000000001);
        drain_all();

        // all-ones key
        write_key_reg(REG_KEY_HIGH, '1);
        write_key_reg(REG_KEY_LOW, '1);
        plain_queue.push_back('0);
        plain_queue.push_back('1);
        plain_queue.push_back(128'h00112233445566778899aabbccddeeff);
        drain_all();

        // key bytes with only one half set
        write_key_reg(REG_KEY_LOW, '0);
        plain_queue.push_back('0);
        plain_queue.push_back(128'h00112233445566778899aabbccddeeff);
        drain_all();

        // random phases with random keys
        for (int ph = 0; ph < 6; ph++) begin
            write_key_reg(REG_KEY_HIGH, rand64());
            write_key_reg(REG_KEY_LOW, rand64());
            for (int n = 0; n < 158; n++) plain_queue.push_back(random_block());
            drain_all();
        end

        if (error_count == 0) begin
            $display("aes128_block_encrypt verification clean");
        end else begin
            $display("aes128_block_encrypt verification failed");
        end
        $finish;
    end
endmodule

[filelist.f]
rtl/aes_pkg.sv
rtl/aes_stream_if.sv
rtl/aes_round_cell.sv
rtl/aes128_block_encrypt.sv
dv/tb_top.sv
